/* design/fqs_pkg.sv */
// Shared types and constants for the searchable FIFO queue.
package fqs_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 4;
  localparam int OCC_W  = 5;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_SRCH = 2'd2,
    KIND_NOP  = 2'd3
  } fqs_kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } fqs_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SRCH,
    S_DONE
  } fqs_state_t;

endpackage

/* design/fifo_queue_with_search.sv */
// Top level of the searchable FIFO queue of signed 32-bit values.
//
// Usage:
//   Input channel (in_valid / in_stall, in_kind, in_value) carries one
//   request per transfer: enqueue, dequeue, search, or a no-op code.
//   Result channel (out_valid / out_stall, out_status, out_data_out,
//   out_position, out_occupancy) returns exactly one result per request,
//   in request order.
//   Requests are handled one at a time. Entries live in a ring buffer
//   memory with registered read data. An enqueue, a no-op or any failed
//   request goes from idle straight to the done state; a dequeue passes
//   through a dequeue state for its one memory read, and a search passes
//   through a scan state, which reads one stored entry per cycle from the
//   oldest and stops at the first match or at the newest entry.
//   An output register parts the two sides: a new request is taken while
//   the previous result still waits; if the receiver stalls, the next
//   result is held internally and no further request is taken.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; the memory is not cleared, as only written entries are read.
module fifo_queue_with_search #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_kind,
  input  logic signed [fqs_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [fqs_pkg::DATA_W-1:0] out_data_out,
  output logic [fqs_pkg::POS_W-1:0]         out_position,
  output logic [fqs_pkg::OCC_W-1:0]         out_occupancy
);
  import fqs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Control state
  fqs_state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;

  // Search scan state and pending result (payload, no reset)
  logic signed [DATA_W-1:0] key_r;
  logic [AW-1:0]            scan_idx_r;
  logic [AW-1:0]            scan_k_r;
  fqs_status_t              res_status_r;
  logic signed [DATA_W-1:0] res_data_r;
  logic [POS_W-1:0]         res_pos_r;
  logic [OCC_W-1:0]         res_occ_r;
  fqs_status_t              out_status_r;
  logic signed [DATA_W-1:0] out_data_r;
  logic [POS_W-1:0]         out_pos_r;
  logic [OCC_W-1:0]         out_occ_r;

  // Memory port signals
  logic                     wr_en;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  logic       accept;
  logic       load_out;
  fqs_kind_t  kind_in;
  logic       is_empty;
  logic       is_full;
  logic       match;
  logic       last;
  logic [POS_W+AW-1:0] pos_ext;
  logic [OCC_W+CW-1:0] occ_ext;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  assign kind_in  = fqs_kind_t'(in_kind);
  assign accept   = in_valid && !in_stall;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(DEPTH));
  // Read data in the scan state belongs to position scan_k_r
  assign match    = (rd_data == key_r);
  assign last     = (CW'(scan_k_r) == count_r - CW'(1));
  assign pos_ext  = {{POS_W{1'b0}}, scan_k_r};
  assign occ_ext  = {{OCC_W{1'b0}}, count_nxt};

  fqs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Pointer and occupancy update, all taken at the input transfer
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (accept) begin
      unique case (kind_in)
        KIND_ENQ: begin
          if (!is_full) begin
            tail_nxt  = ring_next(tail_r);
            count_nxt = count_r + CW'(1);
          end
        end
        KIND_DEQ: begin
          if (!is_empty) begin
            head_nxt  = ring_next(head_r);
            count_nxt = count_r - CW'(1);
          end
        end
        KIND_SRCH, KIND_NOP: begin
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (kind_in == KIND_DEQ && !is_empty) begin
            state_nxt = S_DEQ;
          end else if (kind_in == KIND_SRCH && !is_empty) begin
            state_nxt = S_SRCH;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DEQ: state_nxt = S_DONE;
      S_SRCH: begin
        if (match || last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // State outputs: memory accesses, input stall, result hand-off
  always_comb begin
    in_stall = 1'b1;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = head_r;
    load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          // Start the oldest-entry read for dequeue and search
          rd_en = (kind_in == KIND_DEQ || kind_in == KIND_SRCH) && !is_empty;
          wr_en = (kind_in == KIND_ENQ) && !is_full;
        end
      end
      S_DEQ: begin
      end
      S_SRCH: begin
        // Fetch the next entry unless this one ends the scan
        if (!match && !last) begin
          rd_en   = 1'b1;
          rd_addr = scan_idx_r;
        end
      end
      S_DONE: load_out = !out_valid_r || !out_stall;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result assembly and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data_r <= '0;
      res_pos_r  <= '0;
      res_occ_r  <= occ_ext[OCC_W-1:0];
      key_r      <= in_value;
      scan_idx_r <= ring_next(head_r);
      scan_k_r   <= '0;
      unique case (kind_in)
        KIND_ENQ:  res_status_r <= is_full ? STAT_FULL : STAT_OK;
        KIND_DEQ:  res_status_r <= is_empty ? STAT_EMPTY : STAT_OK;
        KIND_SRCH: res_status_r <= is_empty ? STAT_EMPTY : STAT_OK;
        KIND_NOP:  res_status_r <= STAT_OK;
      endcase
    end
    if (state_r == S_DEQ) begin
      res_data_r <= rd_data;
    end
    if (state_r == S_SRCH) begin
      if (match) begin
        res_status_r <= STAT_OK;
        res_pos_r    <= pos_ext[POS_W-1:0];
      end else if (last) begin
        res_status_r <= STAT_NOTFOUND;
      end else begin
        // Advance the scan by one entry
        scan_idx_r <= ring_next(scan_idx_r);
        scan_k_r   <= scan_k_r + AW'(1);
      end
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_pos_r    <= res_pos_r;
      out_occ_r    <= res_occ_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_data_out  = out_data_r;
  assign out_position  = out_pos_r;
  assign out_occupancy = out_occ_r;

  // Empty and full both mean the ring pointers meet
  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CW'(DEPTH)) |-> (head_r == tail_r))
    else $error("head and tail differ at empty or full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  // Scan never walks past the entries held
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (CW'(scan_k_r) < count_r))
    else $error("search scan past occupancy");

  // A result enters the output register only from the done state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");

  // Queue pointers move only on an input transfer
  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(head_r) && $stable(tail_r) && $stable(count_r)))
    else $error("queue state changed without a transfer");

endmodule

/* design/fqs_store.sv */
// Entry store: one write port, one read port, registered read data.
module fqs_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [fqs_pkg::DATA_W-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr,
  output logic signed [fqs_pkg::DATA_W-1:0] rd_data
);
  import fqs_pkg::*;

  logic signed [DATA_W-1:0] mem_r [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
